[rtl/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular deque unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int OP_W    = 2;
	localparam int DATA_W  = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic {
		CDQ_IDLE,
		CDQ_RESULT
	} state_t;

	typedef struct packed {
		logic exec;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic out_stall;
	} stat_t;

endpackage

`default_nettype wire

[rtl/cdq_in_if.sv]
// ----------------------------------------------------------------------------
// cdq_in_if
// Operation channel of the circular deque unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdq_in_if;

	logic                      valid;
	logic                      ready;
	logic [cdq_pkg::OP_W-1:0]  op;
	logic signed [cdq_pkg::DATA_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);

endinterface

`default_nettype wire

[rtl/cdq_out_if.sv]
// ----------------------------------------------------------------------------
// cdq_out_if
// Result channel of the circular deque unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdq_out_if;

	logic                                valid;
	logic                                ready;
	logic [cdq_pkg::STAT_W-1:0]          status;
	logic signed [cdq_pkg::DATA_W-1:0]   popped_value;
	logic [cdq_pkg::COUNT_W-1:0]         count;

	modport source (output valid, output status, output popped_value, output count,
		input ready);
	modport sink   (input valid, input status, input popped_value, input count,
		output ready);

endinterface

`default_nettype wire

[rtl/cdq_ctrl.sv]
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer that takes one operation, waits for its ring read and hands the
// result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire cdq_pkg::stat_t stat,
	output cdq_pkg::cmd_t       cmd
);

	cdq_pkg::state_t state_q;
	cdq_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdq_pkg::CDQ_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			cdq_pkg::CDQ_IDLE: begin
				if (in_valid) begin
					state_next = cdq_pkg::CDQ_RESULT;
				end
			end
			cdq_pkg::CDQ_RESULT: begin
				if (!stat.out_stall) begin
					state_next = cdq_pkg::CDQ_IDLE;
				end
			end
			default: begin
				state_next = cdq_pkg::CDQ_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			cdq_pkg::CDQ_IDLE: begin
				in_ready = 1'b1;
				cmd.exec = in_valid;
			end
			cdq_pkg::CDQ_RESULT: begin
				cmd.emit = !stat.out_stall;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/cdq_dp.sv]
// ----------------------------------------------------------------------------
// cdq_dp
// Ring store, front and rear indices, element count and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cdq_pkg::cmd_t                 cmd,
	output cdq_pkg::stat_t                     stat,
	input  wire logic [cdq_pkg::OP_W-1:0]      op,
	input  wire logic signed [cdq_pkg::DATA_W-1:0] value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [cdq_pkg::STAT_W-1:0]         out_status,
	output logic signed [cdq_pkg::DATA_W-1:0]  out_popped_value,
	output logic [cdq_pkg::COUNT_W-1:0]        out_count
);

	localparam logic [cdq_pkg::IDX_W-1:0] LAST_IDX = cdq_pkg::IDX_W'(cdq_pkg::DEPTH - 1);
	localparam logic [cdq_pkg::CNT_W-1:0] FULL_CNT = cdq_pkg::CNT_W'(cdq_pkg::DEPTH);

	logic [cdq_pkg::DATA_W-1:0] mem [cdq_pkg::DEPTH];
	logic [cdq_pkg::DATA_W-1:0] rdata_q;

	logic [cdq_pkg::IDX_W-1:0] front_q;
	logic [cdq_pkg::IDX_W-1:0] rear_q;
	logic                      empty_q;
	logic [cdq_pkg::CNT_W-1:0] count_q;
	cdq_pkg::status_t          status_q;
	logic                      pop_ok_q;

	logic                               out_valid_q;
	cdq_pkg::status_t                   out_status_q;
	logic [cdq_pkg::DATA_W-1:0]         out_value_q;
	logic [cdq_pkg::COUNT_W-1:0]        out_count_q;

	cdq_pkg::op_t              op_c;
	logic                      is_push;
	logic                      full;
	logic [cdq_pkg::IDX_W-1:0] front_inc;
	logic [cdq_pkg::IDX_W-1:0] front_dec;
	logic [cdq_pkg::IDX_W-1:0] rear_inc;
	logic [cdq_pkg::IDX_W-1:0] rear_dec;
	logic [cdq_pkg::IDX_W-1:0] front_next;
	logic [cdq_pkg::IDX_W-1:0] rear_next;
	logic                      empty_next;
	logic [cdq_pkg::CNT_W-1:0] count_next;
	cdq_pkg::status_t          status_next;
	logic                      pop_ok_next;
	logic                      wen;
	logic [cdq_pkg::IDX_W-1:0] waddr;
	logic                      ren;
	logic [cdq_pkg::IDX_W-1:0] raddr;

	assign op_c      = cdq_pkg::op_t'(op);
	assign is_push   = (op_c == cdq_pkg::OP_PUSH_FRONT) || (op_c == cdq_pkg::OP_PUSH_BACK);
	assign full      = (count_q == FULL_CNT);
	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign rear_inc  = (rear_q == LAST_IDX) ? '0 : rear_q + 1'b1;
	assign rear_dec  = (rear_q == '0) ? LAST_IDX : rear_q - 1'b1;

	always_comb begin
		front_next  = front_q;
		rear_next   = rear_q;
		empty_next  = empty_q;
		count_next  = count_q;
		status_next = cdq_pkg::ST_DONE;
		pop_ok_next = 1'b0;
		wen         = 1'b0;
		waddr       = '0;
		ren         = 1'b0;
		raddr       = front_q;
		if (is_push) begin
			if (full) begin
				status_next = cdq_pkg::ST_OVERFLOW;
			end else begin
				wen        = 1'b1;
				empty_next = 1'b0;
				count_next = count_q + 1'b1;
				if (empty_q) begin
					front_next = '0;
					rear_next  = '0;
					waddr      = '0;
				end else if (op_c == cdq_pkg::OP_PUSH_FRONT) begin
					front_next = front_dec;
					waddr      = front_dec;
				end else begin
					rear_next = rear_inc;
					waddr     = rear_inc;
				end
			end
		end else begin
			if (empty_q) begin
				status_next = cdq_pkg::ST_UNDERFLOW;
			end else begin
				ren         = 1'b1;
				pop_ok_next = 1'b1;
				count_next  = count_q - 1'b1;
				raddr       = (op_c == cdq_pkg::OP_POP_FRONT) ? front_q : rear_q;
				if (front_q == rear_q) begin
					empty_next = 1'b1;
				end else if (op_c == cdq_pkg::OP_POP_FRONT) begin
					front_next = front_inc;
				end else begin
					rear_next = rear_dec;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wen) begin
			mem[waddr] <= value;
		end
		if (cmd.exec && ren) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			rear_q   <= '0;
			empty_q  <= 1'b1;
			count_q  <= '0;
			status_q <= cdq_pkg::ST_DONE;
			pop_ok_q <= 1'b0;
		end else if (cmd.exec) begin
			front_q  <= front_next;
			rear_q   <= rear_next;
			empty_q  <= empty_next;
			count_q  <= count_next;
			status_q <= status_next;
			pop_ok_q <= pop_ok_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= status_q;
			out_value_q  <= pop_ok_q ? rdata_q : '0;
			out_count_q  <= cdq_pkg::COUNT_W'(count_q);
		end
	end

	assign stat.out_stall  = out_valid_q && !out_ready;
	assign out_valid        = out_valid_q;
	assign out_status       = out_status_q;
	assign out_popped_value = out_value_q;
	assign out_count        = out_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("Element count exceeds the ring depth.");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q == (count_q == '0))
		else $error("Empty flag disagrees with the element count.");

	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && is_push && full |=> status_q == cdq_pkg::ST_OVERFLOW && $stable(count_q))
		else $error("Push onto a full ring did not report overflow.");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && !is_push && empty_q |=> status_q == cdq_pkg::ST_UNDERFLOW && empty_q)
		else $error("Pop from an empty ring did not report underflow.");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("Result was loaded but not presented.");

endmodule

`default_nettype wire

[rtl/circular_deque_unit.sv]
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue of signed 32-bit words held in a ring of DEPTH slots.
//
// The in channel carries an operation (push front, push back, pop front,
// pop back) and a value that only pushes use. Every operation gives one
// result on the out channel: a status (done, overflow, underflow), the
// popped value (zero unless a pop succeeded) and the element count after
// the operation. A push onto a full ring and a pop from an empty ring
// leave the contents unchanged.
// An operation is taken when the unit is idle. Its ring read, status and
// count are registered at the transfer edge, and the result enters the
// output register in the sequencer's result state once the output is not
// stalled; no new operation is taken before then.
// The next operation is taken while the previous result still waits.
// If the receiver stalls, the finished result waits in datapath registers
// until the output register frees up, and no further operation is taken.
// Reset empties the deque and clears the output valid; the ring store
// itself is not cleared, since no slot is read before a push has written it.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cdq_in_if.sink     in_ch,
	cdq_out_if.source  out_ch
);

	cdq_pkg::cmd_t  cmd;
	cdq_pkg::stat_t stat;

	cdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cdq_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.op               (in_ch.op),
		.value            (in_ch.value),
		.out_valid        (out_ch.valid),
		.out_ready        (out_ch.ready),
		.out_status       (out_ch.status),
		.out_popped_value (out_ch.popped_value),
		.out_count        (out_ch.count)
	);

endmodule

`default_nettype wire

[verif/circular_deque_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_unit_test
// Self-checking bench for the circular deque unit. Operations go from a
// queue onto the operation channel. A shadow deque computes the expected
// status, popped value and count of each operation at its transfer. Every
// result transfer is checked against the oldest expectation. The run goes
// through phases with and without random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module circular_deque_unit_test;

	localparam int STALL_LIMIT = 3000;

	typedef struct {
		cdq_pkg::op_t                      op;
		logic signed [cdq_pkg::DATA_W-1:0] value;
	} deque_op_t;

	typedef struct {
		cdq_pkg::status_t                  status;
		logic signed [cdq_pkg::DATA_W-1:0] popped;
		logic [cdq_pkg::COUNT_W-1:0]       count;
	} deque_result_t;

	logic clk = 1'b0;
	logic arst_n;

	cdq_in_if  in_ch ();
	cdq_out_if out_ch ();

	circular_deque_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	deque_op_t     pending_ops[$];
	deque_result_t expected_results[$];
	int            mismatch_count = 0;
	int            idle_cycles = 0;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	int            gen_fill = 0;
	bit            op_taken;
	deque_result_t got;
	deque_result_t want;

	logic signed [cdq_pkg::DATA_W-1:0] ring_words [cdq_pkg::DEPTH];
	int head_idx = 0;
	int tail_idx = 0;
	bit ring_empty = 1'b1;

	function automatic int step_up(int idx);
		return (idx == cdq_pkg::DEPTH - 1) ? 0 : idx + 1;
	endfunction

	function automatic int step_down(int idx);
		return (idx == 0) ? cdq_pkg::DEPTH - 1 : idx - 1;
	endfunction

	function automatic int held_elements();
		if (ring_empty)
			return 0;
		return ((tail_idx - head_idx + cdq_pkg::DEPTH) % cdq_pkg::DEPTH) + 1;
	endfunction

	function automatic deque_result_t apply_deque_op(cdq_pkg::op_t op,
		logic signed [cdq_pkg::DATA_W-1:0] value);
		deque_result_t res;
		res.status = cdq_pkg::ST_DONE;
		res.popped = '0;
		if (op == cdq_pkg::OP_PUSH_FRONT || op == cdq_pkg::OP_PUSH_BACK) begin
			if (held_elements() >= cdq_pkg::DEPTH) begin
				res.status = cdq_pkg::ST_OVERFLOW;
			end else if (ring_empty) begin
				head_idx = 0;
				tail_idx = 0;
				ring_empty = 1'b0;
				ring_words[0] = value;
			end else if (op == cdq_pkg::OP_PUSH_FRONT) begin
				head_idx = step_down(head_idx);
				ring_words[head_idx] = value;
			end else begin
				tail_idx = step_up(tail_idx);
				ring_words[tail_idx] = value;
			end
		end else if (ring_empty) begin
			res.status = cdq_pkg::ST_UNDERFLOW;
		end else if (op == cdq_pkg::OP_POP_FRONT) begin
			res.popped = ring_words[head_idx];
			if (head_idx == tail_idx)
				ring_empty = 1'b1;
			else
				head_idx = step_up(head_idx);
		end else begin
			res.popped = ring_words[tail_idx];
			if (head_idx == tail_idx)
				ring_empty = 1'b1;
			else
				tail_idx = step_down(tail_idx);
		end
		res.count = cdq_pkg::COUNT_W'(held_elements());
		return res;
	endfunction

	task automatic report_mismatch(string text);
		if (mismatch_count < 10)
			$display("%0t: %s", $realtime, text);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		op_taken = 1'b0;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				expected_results.push_back(apply_deque_op(cdq_pkg::op_t'(in_ch.op),
					in_ch.value));
				void'(pending_ops.pop_front());
				op_taken = 1'b1;
			end
			if (!in_ch.valid || op_taken) begin
				if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_ch.valid <= 1'b1;
					in_ch.op    <= pending_ops[0].op;
					in_ch.value <= pending_ops[0].value;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.status = cdq_pkg::status_t'(out_ch.status);
				got.popped = out_ch.popped_value;
				got.count  = out_ch.count;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result: status %0d popped %0d count %0d",
						got.status, got.popped, got.count));
				end else begin
					want = expected_results.pop_front();
					if (got.status != want.status)
						report_mismatch($sformatf("status: expected %0d, got %0d",
							want.status, got.status));
					if (got.popped != want.popped)
						report_mismatch($sformatf("popped_value: expected %0d, got %0d",
							want.popped, got.popped));
					if (got.count != want.count)
						report_mismatch($sformatf("count: expected %0d, got %0d",
							want.count, got.count));
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic queue_op(cdq_pkg::op_t op, logic signed [cdq_pkg::DATA_W-1:0] value);
		deque_op_t item;
		item.op = op;
		item.value = value;
		pending_ops.push_back(item);
		if (op == cdq_pkg::OP_PUSH_FRONT || op == cdq_pkg::OP_PUSH_BACK) begin
			if (gen_fill < cdq_pkg::DEPTH)
				gen_fill++;
		end else if (gen_fill > 0) begin
			gen_fill--;
		end
	endtask

	function automatic logic signed [cdq_pkg::DATA_W-1:0] pick_value();
		if ($urandom_range(7) != 0)
			return $urandom;
		case ($urandom_range(3))
			0: return {1'b1, {(cdq_pkg::DATA_W-1){1'b0}}};
			1: return {1'b0, {(cdq_pkg::DATA_W-1){1'b1}}};
			2: return '0;
			default: return '1;
		endcase
	endfunction

	task automatic queue_random_ops(int total);
		int push_pct;
		int burst;
		bit do_push;
		while (total > 0) begin
			case ($urandom_range(2))
				0: push_pct = 85;
				1: push_pct = 15;
				default: push_pct = 50;
			endcase
			burst = $urandom_range(4, 40);
			while (burst > 0 && total > 0) begin
				if ($urandom_range(9) == 0)
					queue_op(cdq_pkg::op_t'($urandom_range(3)), pick_value());
				else begin
					do_push = ($urandom_range(99) < push_pct);
					if (do_push)
						queue_op($urandom_range(1) ? cdq_pkg::OP_PUSH_BACK
							: cdq_pkg::OP_PUSH_FRONT, pick_value());
					else
						queue_op($urandom_range(1) ? cdq_pkg::OP_POP_BACK
							: cdq_pkg::OP_POP_FRONT, pick_value());
				end
				burst--;
				total--;
			end
		end
	endtask

	task automatic wait_for_drain();
		while (pending_ops.size() > 0 || expected_results.size() > 0)
			@(negedge clk);
	endtask

	initial begin
		in_ch.valid  = 1'b0;
		in_ch.op     = cdq_pkg::OP_PUSH_FRONT;
		in_ch.value  = '0;
		out_ch.ready = 1'b0;
		arst_n       = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_op(cdq_pkg::OP_POP_FRONT, 32'sd5);
		queue_op(cdq_pkg::OP_POP_BACK, -32'sd5);
		queue_op(cdq_pkg::OP_PUSH_FRONT, {1'b1, {(cdq_pkg::DATA_W-1){1'b0}}});
		queue_op(cdq_pkg::OP_POP_BACK, '0);
		queue_op(cdq_pkg::OP_PUSH_BACK, {1'b0, {(cdq_pkg::DATA_W-1){1'b1}}});
		queue_op(cdq_pkg::OP_POP_FRONT, '1);
		for (int i = 0; i < cdq_pkg::DEPTH; i++)
			queue_op((i % 2) ? cdq_pkg::OP_PUSH_BACK : cdq_pkg::OP_PUSH_FRONT,
				(i % 2) ? 32'h5555_5555 ^ i : 32'hAAAA_AAAA ^ i);
		queue_op(cdq_pkg::OP_PUSH_FRONT, '1);
		queue_op(cdq_pkg::OP_PUSH_BACK, '0);
		queue_random_ops(250);
		wait_for_drain();

		send_idle_pct = 71;
		queue_random_ops(270);
		wait_for_drain();

		send_idle_pct = 0;
		recv_stall_pct = 71;
		queue_random_ops(270);
		wait_for_drain();

		send_idle_pct = 8;
		recv_stall_pct = 8;
		queue_random_ops(270);
		wait_for_drain();

		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[files.f]
rtl/cdq_pkg.sv
rtl/cdq_in_if.sv
rtl/cdq_out_if.sv
rtl/cdq_ctrl.sv
rtl/cdq_dp.sv
rtl/circular_deque_unit.sv
verif/circular_deque_unit_test.sv
